FILE: design/pooling_2d_max_average_defines.svh
// Assertion macros shared by the pooling block's RTL.
// No dependencies; define NO_ASSERTIONS to compile the checks away.
`ifndef POOLING_2D_MAX_AVERAGE_DEFINES_SVH
`define POOLING_2D_MAX_AVERAGE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define POOL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define POOL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define POOL_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define POOL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: design/pool2d_pkg.sv
// Types, widths and codes shared by the pooling block.
// No dependencies.
package pool2d_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int IMAGE_W    = 9;
    localparam int KERNEL_W   = 4;
    localparam int STRIDE_W   = 8;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 9;
    localparam int SUM_W      = 24;
    localparam int DIV_W      = 24;
    localparam int DIVISOR_W  = 8;
    localparam int STEP_W     = 5;

    localparam logic [CFG_ADDR_W-1:0] CFG_IMAGE_SIZE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_KERNEL_SIZE = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STRIDE_STEP = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_POOL_MODE   = 2'd3;

    localparam logic MODE_MAX = 1'b0;
    localparam logic MODE_AVG = 1'b1;

    typedef struct packed {
        logic [IMAGE_W-1:0]  image_size;
        logic [KERNEL_W-1:0] kernel_size;
        logic [STRIDE_W-1:0] stride_step;
        logic                pool_mode;
    } cfg_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_W-1:0]     dividend;
        logic [DIVISOR_W-1:0] divisor;
        logic [STEP_W-1:0]    steps;
    } div_req_t;

    typedef struct packed {
        logic                 busy;
        logic                 done;
        logic [DIV_W-1:0]     quotient;
        logic [DIVISOR_W-1:0] remainder;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL_MOD,
        ST_ROW_MOD,
        ST_READ,
        ST_DRAIN,
        ST_FINISH,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

FILE: design/pool2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pool2d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/pool2d_div.sv
// Shared restoring divider: one quotient bit per cycle, remainder kept.
// Depends on pool2d_pkg for the request and response structs.
module pool2d_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pool2d_pkg::div_req_t req,
    output pool2d_pkg::div_rsp_t rsp
);
    import pool2d_pkg::*;

    logic                 busy_reg, busy_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dsr_reg, dsr_next;
    logic [DIVISOR_W:0]   trial;
    logic [DIVISOR_W:0]   diff;
    logic                 ge;
    logic                 done;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};
    assign diff  = trial - {1'b0, dsr_reg};
    assign done  = busy_reg && (cnt_reg == '0);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        priority if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.steps;
            dvd_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg && (cnt_reg != '0))
        begin
            dvd_next = {dvd_reg[DIV_W-2:0], ge};
            rem_next = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            cnt_next = cnt_reg - 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done;
    assign rsp.quotient  = dvd_reg;
    assign rsp.remainder = rem_reg;

endmodule

FILE: design/pool2d_seq.sv
// Sequencer: image position tracking, window checks, line store reads,
// max/sum accumulation and the output register.
// Depends on pool2d_pkg and pooling_2d_max_average_defines.svh.
`include "pooling_2d_max_average_defines.svh"

module pool2d_seq #(
    parameter int MAX_IMAGE  = 256,
    parameter int MAX_KERNEL = 8,
    localparam int AW = (MAX_KERNEL * MAX_IMAGE > 1) ? $clog2(MAX_KERNEL * MAX_IMAGE) : 1
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pool2d_pkg::cfg_t                     cfg,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pool2d_pkg::SAMPLE_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pool2d_pkg::SAMPLE_W-1:0]      m_tdata,
    output logic                                 m_tlast,
    output logic                                 ram_we,
    output logic [AW-1:0]                        ram_waddr,
    output logic [pool2d_pkg::SAMPLE_W-1:0]      ram_wdata,
    output logic [AW-1:0]                        ram_raddr,
    input  logic [pool2d_pkg::SAMPLE_W-1:0]      ram_rdata,
    output pool2d_pkg::div_req_t                 div_req,
    input  pool2d_pkg::div_rsp_t                 div_rsp
);
    import pool2d_pkg::*;

    localparam int IW  = (MAX_IMAGE > 1) ? $clog2(MAX_IMAGE) : 1;
    localparam int SLW = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
    localparam int CW  = ((IW > IMAGE_W) ? IW : IMAGE_W) + 1;
    localparam logic [AW-1:0]  ROW_SPAN  = AW'(MAX_IMAGE);
    localparam logic [SLW-1:0] SLOT_LAST = SLW'(MAX_KERNEL - 1);
    localparam logic [DIV_W-1:0] MEAN_MAG_MAX = DIV_W'(32768);

    state_t state_reg, state_next;

    logic [IW-1:0]   row_reg, row_next;
    logic [IW-1:0]   col_reg, col_next;
    logic [SLW-1:0]  slot_reg, slot_next;
    logic [IW-1:0]   x0_reg, x0_next;
    logic [IW-1:0]   y0_reg, y0_next;
    logic [SLW-1:0]  slot0_reg, slot0_next;
    logic            last_reg, last_next;
    logic [KERNEL_W-1:0] rcnt_reg, rcnt_next;
    logic [KERNEL_W-1:0] ccnt_reg, ccnt_next;
    logic [SLW-1:0]  rslot_reg, rslot_next;
    logic            rd_vld_reg;
    logic signed [SAMPLE_W-1:0] best_reg, best_next;
    logic signed [SUM_W-1:0]    sum_reg, sum_next;
    logic [SAMPLE_W-1:0] result_reg, result_next;
    logic            out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] out_data_reg;
    logic            out_last_reg;
    logic            out_load;

    logic [CW-1:0]       n_eff;
    logic [KERNEL_W-1:0] k_eff;
    logic [STRIDE_W-1:0] s_eff;
    logic [CW-1:0]       k_cw, row_cw, col_cw, lim;
    logic [IW-1:0]       x0_cur, y0_cur;
    logic                fit, last_cur;
    logic                in_xfer;
    logic [DIVISOR_W-1:0] k_wide, kk;
    logic [DIV_W-1:0]    sum_mag;
    logic [SAMPLE_W-1:0] q16;
    logic signed [SAMPLE_W-1:0] rd_sample;

    assign n_eff = (cfg.image_size == '0) ? CW'(1) :
                   (CW'(cfg.image_size) > CW'(MAX_IMAGE)) ? CW'(MAX_IMAGE) :
                   CW'(cfg.image_size);
    assign k_eff = (cfg.kernel_size == '0) ? KERNEL_W'(1) :
                   (CW'(cfg.kernel_size) > CW'(MAX_KERNEL)) ? KERNEL_W'(MAX_KERNEL) :
                   cfg.kernel_size;
    assign s_eff = (cfg.stride_step == '0) ? STRIDE_W'(1) : cfg.stride_step;

    assign k_cw   = CW'(k_eff);
    assign row_cw = CW'(row_reg);
    assign col_cw = CW'(col_reg);
    assign lim    = n_eff - k_cw;
    assign fit    = (row_cw < n_eff) && (col_cw < n_eff) && (k_cw <= n_eff) &&
                    (row_cw + CW'(1) >= k_cw) && (col_cw + CW'(1) >= k_cw);
    assign x0_cur = IW'(col_cw + CW'(1) - k_cw);
    assign y0_cur = IW'(row_cw + CW'(1) - k_cw);
    assign last_cur = (CW'(y0_cur) + CW'(s_eff) > lim) && (CW'(x0_cur) + CW'(s_eff) > lim);

    assign k_wide  = DIVISOR_W'(k_eff);
    assign kk      = k_wide * k_wide;
    assign sum_mag = sum_reg[SUM_W-1] ? DIV_W'(-sum_reg) : DIV_W'(sum_reg);
    assign q16     = div_rsp.quotient[SAMPLE_W-1:0];
    assign rd_sample = ram_rdata;

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;

    assign ram_we    = in_xfer;
    assign ram_waddr = AW'(slot_reg) * ROW_SPAN + AW'(col_reg);
    assign ram_wdata = s_tdata;
    assign ram_raddr = AW'(rslot_reg) * ROW_SPAN + AW'(x0_reg) + AW'(ccnt_reg);

    always_comb
    begin
        row_next  = row_reg;
        col_next  = col_reg;
        slot_next = slot_reg;
        if (in_xfer)
        begin
            if (col_cw + CW'(1) >= n_eff)
            begin
                col_next = '0;
                if (row_cw + CW'(1) >= n_eff)
                begin
                    row_next  = '0;
                    slot_next = '0;
                end
                else
                begin
                    row_next  = row_reg + 1'b1;
                    slot_next = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        x0_next     = x0_reg;
        y0_next     = y0_reg;
        slot0_next  = slot0_reg;
        last_next   = last_reg;
        rcnt_next   = rcnt_reg;
        ccnt_next   = ccnt_reg;
        rslot_next  = rslot_reg;
        best_next   = best_reg;
        sum_next    = sum_reg;
        result_next = result_reg;
        out_load    = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = s_eff;
        div_req.steps    = STEP_W'(IW);

        if (rd_vld_reg)
        begin
            if (rd_sample > best_reg)
            begin
                best_next = rd_sample;
            end
            sum_next = sum_reg + SUM_W'(rd_sample);
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    x0_next    = x0_cur;
                    y0_next    = y0_cur;
                    slot0_next = slot_reg;
                    last_next  = last_cur;
                    if (fit)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(x0_cur) << (DIV_W - IW);
                        state_next       = ST_COL_MOD;
                    end
                end
            end
            ST_COL_MOD:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder == '0)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(y0_reg) << (DIV_W - IW);
                        state_next       = ST_ROW_MOD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_ROW_MOD:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.remainder == '0)
                    begin
                        rcnt_next  = '0;
                        ccnt_next  = '0;
                        rslot_next = slot0_reg;
                        best_next  = {1'b1, {(SAMPLE_W-1){1'b0}}};
                        sum_next   = '0;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_READ:
            begin
                if (ccnt_reg == k_eff - 1'b1)
                begin
                    ccnt_next = '0;
                    if (rcnt_reg == k_eff - 1'b1)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        rcnt_next  = rcnt_reg + 1'b1;
                        rslot_next = (rslot_reg == '0) ? SLOT_LAST : rslot_reg - 1'b1;
                    end
                end
                else
                begin
                    ccnt_next = ccnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (cfg.pool_mode == MODE_AVG)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = sum_mag;
                    div_req.divisor  = kk;
                    div_req.steps    = STEP_W'(DIV_W);
                    state_next       = ST_DIV;
                end
                else
                begin
                    result_next = best_reg;
                    state_next  = ST_EMIT;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    result_next = sum_reg[SUM_W-1] ? -q16 : q16;
                    state_next  = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            slot_reg      <= '0;
            rcnt_reg      <= '0;
            ccnt_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            slot_reg      <= slot_next;
            rcnt_reg      <= rcnt_next;
            ccnt_reg      <= ccnt_next;
            rd_vld_reg    <= (state_reg == ST_READ);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x0_reg     <= x0_next;
        y0_reg     <= y0_next;
        slot0_reg  <= slot0_next;
        last_reg   <= last_next;
        rslot_reg  <= rslot_next;
        best_reg   <= best_next;
        sum_reg    <= sum_next;
        result_reg <= result_next;
        if (out_load)
        begin
            out_data_reg <= result_next;
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    `POOL_ASSERT_IMPL(a_write_only_idle, clk, rst_n, ram_we, state_reg == ST_IDLE, "line store written outside idle")
    `POOL_ASSERT_IMPL(a_read_in_window, clk, rst_n, state_reg == ST_READ, (rcnt_reg < k_eff) && (ccnt_reg < k_eff), "window read counter out of range")
    `POOL_ASSERT_IMPL(a_div_not_busy, clk, rst_n, div_req.start, !div_rsp.busy || div_rsp.done, "divider restarted while busy")
    `POOL_ASSERT_IMPL(a_mean_bound, clk, rst_n, (state_reg == ST_DIV) && div_rsp.done, div_rsp.quotient <= MEAN_MAG_MAX, "mean magnitude out of range")
    `POOL_ASSERT_NEXT(a_no_window_free, clk, rst_n, in_xfer && !fit, state_reg == ST_IDLE, "item without window held the block")

endmodule

FILE: design/pooling_2d_max_average.sv
// Streaming 2-D max/average pooling over a square signed Q8.8 image.
// Channels: s_* carries one sample per transfer in row-major order; m_* carries
// one pooled value per transfer with m_tlast on the final window of the image;
// cfg_* writes image_size (0), kernel_size (1), stride_step (2), pool_mode (3);
// the user must write them only while the block is idle, which the block itself
// does not enforce. cfg_ready is always high.
// Flow per sample: if its window does not fit, s_tready stays high; otherwise the
// column origin and then the row origin are checked against the stride grid on
// the shared one-bit-per-cycle divider, and an origin off the grid ends the
// sample; a window on the grid reads k * k entries through the single line store
// read port, where k is the kernel side, and average mode adds a 24-bit divide.
// Reset: positions to zero, registers to 256 / 2 / 2 / max. The line store is
// not cleared; every window in a full image reads only written entries.
// Stall: a result waits in the output register while the next sample is taken;
// the block holds the following result until that register is free.
module pooling_2d_max_average #(
    parameter int MAX_IMAGE  = 256,
    parameter int MAX_KERNEL = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pool2d_pkg::SAMPLE_W-1:0]      s_tdata,   // [15:0] sample_value
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pool2d_pkg::SAMPLE_W-1:0]      m_tdata,   // [15:0] pooled_value
    output logic                                 m_tlast,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pool2d_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [pool2d_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pool2d_pkg::*;

    localparam int DEPTH = MAX_KERNEL * MAX_IMAGE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cfg_t cfg_reg, cfg_next;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [SAMPLE_W-1:0] ram_wdata;
    logic [AW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;
    div_req_t            div_req;
    div_rsp_t            div_rsp;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_addr)
                CFG_IMAGE_SIZE:  cfg_next.image_size  = cfg_data[IMAGE_W-1:0];
                CFG_KERNEL_SIZE: cfg_next.kernel_size = cfg_data[KERNEL_W-1:0];
                CFG_STRIDE_STEP: cfg_next.stride_step = cfg_data[STRIDE_W-1:0];
                CFG_POOL_MODE:   cfg_next.pool_mode   = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.image_size  <= IMAGE_W'(256);
            cfg_reg.kernel_size <= KERNEL_W'(2);
            cfg_reg.stride_step <= STRIDE_W'(2);
            cfg_reg.pool_mode   <= MODE_MAX;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pool2d_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pool2d_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pool2d_seq #(
        .MAX_IMAGE  (MAX_IMAGE),
        .MAX_KERNEL (MAX_KERNEL)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .div_req   (div_req),
        .div_rsp   (div_rsp)
    );

endmodule

FILE: tb/sv/testbench.sv
// Self-checking testbench for the 2-D max/average pooling block.
// Predicts each pooled window from the accepted samples and checks the output stream.
// Depends on pool2d_pkg and the pooling_2d_max_average RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pool2d_pkg::*;

    localparam int MAX_SIDE      = 256;
    localparam int MAX_WIN       = 8;
    localparam int LINE_DEPTH    = MAX_SIDE * MAX_WIN;
    localparam int PHASE_ITEMS   = 180;
    localparam int SETTLE_CYCLES = 200;
    localparam int DRAIN_LIMIT   = 100000;
    localparam int MAX_REPORTS   = 40;
    localparam int RUN_LIMIT_NS  = 60_000_000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                last;
    } pooled_t;

    class window_board;
        logic [IMAGE_W-1:0]  image_reg;
        logic [KERNEL_W-1:0] kernel_reg;
        logic [STRIDE_W-1:0] stride_reg;
        logic                mode_reg;
        logic [SAMPLE_W-1:0] line_rows [0:LINE_DEPTH-1];
        int unsigned         row_pos;
        int unsigned         col_pos;
        pooled_t             pending_pools [$];
        int                  errors;

        function new();
            image_reg  = 9'd256;
            kernel_reg = 4'd2;
            stride_reg = 8'd2;
            mode_reg   = MODE_MAX;
            row_pos    = 0;
            col_pos    = 0;
            errors     = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_IMAGE_SIZE:  image_reg  = val[IMAGE_W-1:0];
                CFG_KERNEL_SIZE: kernel_reg = val[KERNEL_W-1:0];
                CFG_STRIDE_STEP: stride_reg = val[STRIDE_W-1:0];
                CFG_POOL_MODE:   mode_reg   = val[0];
                default:         ;
            endcase
        endfunction

        function void take_sample(logic [SAMPLE_W-1:0] sample);
            int unsigned n;
            int unsigned k;
            int unsigned s;
            int unsigned y0;
            int unsigned x0;
            int unsigned r;
            int unsigned c;
            int unsigned final_origin;
            int          best;
            int          total;
            int          v;
            int          result;
            pooled_t     pool;
            n = (image_reg == 0) ? 1 : ((image_reg > MAX_SIDE) ? MAX_SIDE : image_reg);
            k = (kernel_reg == 0) ? 1 : ((kernel_reg > MAX_WIN) ? MAX_WIN : kernel_reg);
            s = (stride_reg == 0) ? 1 : stride_reg;
            line_rows[(row_pos % MAX_WIN) * MAX_SIDE + col_pos] = sample;
            if (row_pos < n && col_pos < n && k <= n && row_pos + 1 >= k && col_pos + 1 >= k)
            begin
                y0 = row_pos + 1 - k;
                x0 = col_pos + 1 - k;
                if (y0 % s == 0 && x0 % s == 0)
                begin
                    best  = -32768;
                    total = 0;
                    for (r = y0; r <= row_pos; r++)
                    begin
                        for (c = x0; c <= col_pos; c++)
                        begin
                            v = $signed(line_rows[(r % MAX_WIN) * MAX_SIDE + c]);
                            if (v > best)
                                best = v;
                            total += v;
                        end
                    end
                    result       = (mode_reg == MODE_AVG) ? total / int'(k * k) : best;
                    final_origin = ((n - k) / s) * s;
                    pool.value   = result[SAMPLE_W-1:0];
                    pool.last    = (y0 == final_origin && x0 == final_origin);
                    pending_pools.push_back(pool);
                end
            end
            col_pos++;
            if (col_pos >= n)
            begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= n)
                    row_pos = 0;
            end
        endfunction

        function void match_output(logic [SAMPLE_W-1:0] value, logic last);
            pooled_t want;
            if (pending_pools.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: pooled value expected none, actual %h last %b",
                             $time, value, last);
                return;
            end
            want = pending_pools.pop_front();
            if (value !== want.value)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: pooled value expected %h, actual %h",
                             $time, want.value, value);
            end
            if (last !== want.last)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: frame last expected %b, actual %b",
                             $time, want.last, last);
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [SAMPLE_W-1:0]   s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]   m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_ADDR_W-1:0] cfg_addr  = CFG_IMAGE_SIZE;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int          idle_pct  = 0;
    int          stall_pct = 0;
    window_board board;

    pooling_2d_max_average uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_addr  (cfg_addr),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                board.take_sample(s_tdata);
            if (m_tvalid && m_tready)
                board.match_output(m_tdata, m_tlast);
        end
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_reg(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain_pools();
        int waited;
        @(negedge clk);
        s_tvalid <= 1'b0;
        waited = 0;
        while (board.pending_pools.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] side,
                             input logic [CFG_DATA_W-1:0] kernel,
                             input logic [CFG_DATA_W-1:0] stride,
                             input logic mode);
        drain_pools();
        write_reg(CFG_IMAGE_SIZE, side);
        write_reg(CFG_KERNEL_SIZE, kernel);
        write_reg(CFG_STRIDE_STEP, stride);
        write_reg(CFG_POOL_MODE, {{(CFG_DATA_W-1){1'b0}}, mode});
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return 16'h8000;
        if (pick < 10)
            return 16'h7FFF;
        if (pick < 15)
            return 16'($urandom_range(0, 6)) - 16'd3;
        return 16'($urandom);
    endfunction

    task automatic run_phase(input int idle, input int stall);
        int                    sent;
        int                    pick;
        int                    side;
        int                    images;
        logic [CFG_DATA_W-1:0] side_reg;
        logic [CFG_DATA_W-1:0] kernel_reg;
        logic [CFG_DATA_W-1:0] stride_reg;
        idle_pct  = idle;
        stall_pct = stall;
        sent      = 0;
        while (sent < PHASE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
                side_reg = 0;
            else if (pick < 80)
                side_reg = $urandom_range(1, 8);
            else
                side_reg = $urandom_range(9, 20);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                kernel_reg = $urandom_range(1, 4);
            else if (pick < 90)
                kernel_reg = $urandom_range(5, 8);
            else
                kernel_reg = $urandom_range(0, 15);
            pick = $urandom_range(0, 99);
            if (pick < 40)
                stride_reg = 1;
            else if (pick < 75)
                stride_reg = $urandom_range(2, 3);
            else if (pick < 85)
                stride_reg = 0;
            else if (pick < 95)
                stride_reg = $urandom_range(4, 8);
            else
                stride_reg = $urandom_range(9, 255);
            configure(side_reg, kernel_reg, stride_reg, 1'($urandom_range(0, 1)));
            side   = (side_reg == 0) ? 1 : side_reg;
            images = $urandom_range(1, 2);
            repeat (images * side * side) send_sample(random_sample());
            sent += images * side * side;
        end
    endtask

    initial
    begin
        board = new();
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // zero size, kernel and stride fall back to one: each sample is its own window
        configure(0, 0, 0, MODE_MAX);
        send_sample(16'h8000);
        configure(0, 0, 0, MODE_AVG);
        send_sample(16'h7FFF);
        // negative sum truncates toward zero
        configure(2, 2, 2, MODE_AVG);
        send_sample(16'hFFFF);
        repeat (3) send_sample(16'h0000);
        configure(2, 2, 255, MODE_MAX);
        repeat (4) send_sample(16'h8000);
        configure(2, 2, 1, MODE_AVG);
        repeat (4) send_sample(16'h7FFF);
        // saturated kernel wider than the image: no output
        configure(2, 15, 1, MODE_AVG);
        repeat (4) send_sample(16'h7FFF);

        run_phase(0, 0);
        run_phase(75, 0);
        run_phase(0, 75);
        run_phase(34, 34);

        // oversized image saturates to the largest side: windows at both ends of the first row
        idle_pct  = 0;
        stall_pct = 0;
        configure(9'h1FF, 1, 255, MODE_AVG);
        repeat (MAX_SIDE) send_sample(random_sample());

        drain_pools();
        if (board.pending_pools.size() != 0)
        begin
            board.errors++;
            $display("%0t: pooled values expected %0d more, actual none",
                     $time, board.pending_pools.size());
        end
        if (board.errors == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("testbench failed");
        $finish;
    end

endmodule

FILE: pooling_2d_max_average.f
+incdir+design
design/pool2d_pkg.sv
design/pool2d_ram.sv
design/pool2d_div.sv
design/pool2d_seq.sv
design/pooling_2d_max_average.sv
tb/sv/testbench.sv
